// ===== hdl/bhc_pkg.sv =====
// Shared types, codes and the commutation table for the BLDC hall commutator.
package bhc_pkg;

    // Item modes
    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DUTY  = 2'd0;
    localparam logic [1:0] CFG_EPR   = 2'd1;
    localparam logic [1:0] CFG_AVG   = 2'd2;

    // Configuration reset values
    localparam logic [7:0] EPR_RESET = 8'd42;
    localparam logic [7:0] AVG_RESET = 8'd100;

    // Phase drive codes
    localparam logic [1:0] DRV_OFF = 2'd0;
    localparam logic [1:0] DRV_LOW = 2'd1;
    localparam logic [1:0] DRV_PWM = 2'd2;

    // Hall codes with no commutation step
    localparam logic [2:0] HALL_NONE = 3'b000;
    localparam logic [2:0] HALL_ALL  = 3'b111;

    // Speed arithmetic
    localparam int          DIV_W      = 24;
    localparam logic [15:0] RPM_NUM    = 16'd60000;
    localparam logic [15:0] RPM_SAT    = 16'hFFFF;
    localparam logic [4:0]  SAMPLE_LAST = 5'd15;
    localparam logic [4:0]  AVG_LAST    = 5'd23;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_SAMPLE,
        ST_ACC,
        ST_DIV_AVG,
        ST_DONE
    } t_state;

    // Drive vector for a hall code: phase A in bits 1:0, B in 3:2, C in 5:4
    function automatic logic [5:0] commutate(input logic [2:0] hall);
        logic [5:0] v;
        unique case (hall)
            3'd1:    v = {DRV_LOW, DRV_OFF, DRV_PWM};
            3'd2:    v = {DRV_OFF, DRV_PWM, DRV_LOW};
            3'd3:    v = {DRV_LOW, DRV_PWM, DRV_OFF};
            3'd4:    v = {DRV_PWM, DRV_LOW, DRV_OFF};
            3'd5:    v = {DRV_OFF, DRV_LOW, DRV_PWM};
            3'd6:    v = {DRV_PWM, DRV_OFF, DRV_LOW};
            default: v = {DRV_OFF, DRV_OFF, DRV_OFF};
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/bhc_div_step.sv =====
// One restoring-division step: shift in a dividend bit, compare, subtract.
module bhc_div_step #(
    parameter int W = bhc_pkg::DIV_W
) (
    input  logic [W-1:0] i_rem,
    input  logic         i_bit,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_rem,
    output logic         o_q
);

    logic [W:0] w_trial;
    logic [W:0] w_diff;

    // Trial remainder stays below twice the divisor, so one subtract suffices
    assign w_trial = {i_rem, i_bit};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign o_q     = (w_trial >= {1'b0, i_divisor});
    assign o_rem   = o_q ? w_diff[W-1:0] : w_trial[W-1:0];

endmodule

// ===== hdl/bldc_hall_commutator_with_speed.sv =====
// Top level: six-step hall commutator with averaged rpm over a shared divide step.
// Each transaction updates the commutation state when it is accepted and returns one
// result through an output register, so a new transaction is taken while the last
// result waits. Start, stop and ignored modes go from accept straight to the done
// state. A hall edge runs the per-edge sample divide unless the period is zero or
// above 60000 ms, and the edge that publishes rpm also runs the average divide.
// Both divides run one bit per cycle on a single restoring divide step; o_stall is
// high while a transaction is in the sequencer or a finished result cannot yet move
// to the output register. duty_percent writes are accepted and have no effect on
// any result.
module bldc_hall_commutator_with_speed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input transactions
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_hall,
    input  logic [31:0] i_time_ms,
    // result transactions
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_drive_a,
    output logic [1:0]  o_drive_b,
    output logic [1:0]  o_drive_c,
    output logic        o_gate_enable,
    output logic [15:0] o_rpm,
    output logic        o_rpm_updated,
    output logic        o_hall_invalid
);
    import bhc_pkg::*;

    t_state r_state, n_state;

    logic        r_running, r_pending;
    logic [5:0]  r_drive;
    logic [31:0] r_last;
    logic [7:0]  r_count;
    logic [23:0] r_sum;
    logic [15:0] r_rpm;
    logic [7:0]  r_epr, r_avg;
    logic        r_o_valid;

    logic [31:0] r_period;
    logic [23:0] r_den, r_rem, r_quo;
    logic [4:0]  r_step;
    logic [15:0] r_sample;
    logic        r_updated, r_invalid;
    logic [5:0]  r_o_drive;
    logic        r_o_gate;
    logic [15:0] r_o_rpm;
    logic        r_o_updated, r_o_invalid;

    logic        w_accept, w_out_free, w_div_run, w_last_step, w_hall_ok;
    logic        w_period_zero, w_period_big, w_publish;
    logic [7:0]  w_epr, w_avg, w_count_next;
    logic [23:0] w_den, w_divisor, w_rem_next, w_quo_next, w_sum_next;
    logic        w_q;

    // Effective divisors: zero counts as one
    assign w_epr = (r_epr == 8'd0) ? 8'd1 : r_epr;
    assign w_avg = (r_avg == 8'd0) ? 8'd1 : r_avg;

    assign w_hall_ok     = (i_hall != HALL_NONE) && (i_hall != HALL_ALL);
    assign w_period_zero = (r_period == 32'd0);
    assign w_period_big  = (r_period > {16'd0, RPM_NUM});
    assign w_den         = 24'(r_period[15:0]) * 24'(w_epr);
    assign w_sum_next    = r_sum + 24'(r_sample);
    assign w_count_next  = r_count + 8'd1;
    assign w_publish     = (w_count_next >= w_avg);

    // Shared divide step
    assign w_divisor = (r_state == ST_DIV_AVG) ? 24'(w_avg) : r_den;

    bhc_div_step #(.W(DIV_W)) u_div_step (
        .i_rem     (r_rem),
        .i_bit     (r_quo[DIV_W-1]),
        .i_divisor (w_divisor),
        .o_rem     (w_rem_next),
        .o_q       (w_q)
    );

    assign w_quo_next = {r_quo[DIV_W-2:0], w_q};

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = (i_mode == MODE_EDGE) ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                n_state = (w_period_zero || w_period_big) ? ST_ACC : ST_DIV_SAMPLE;
            end
            ST_DIV_SAMPLE: begin
                if (w_last_step) n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = w_publish ? ST_DIV_AVG : ST_DONE;
            end
            ST_DIV_AVG: begin
                if (w_last_step) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer decodes
    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        w_accept    = i_valid && (r_state == ST_IDLE);
        w_out_free  = !r_o_valid || !i_stall;
        w_div_run   = (r_state == ST_DIV_SAMPLE) || (r_state == ST_DIV_AVG);
        w_last_step = (r_step == 5'd0);
    end

    // Control state, configuration and speed accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_running <= 1'b0;
            r_pending <= 1'b0;
            r_drive   <= '0;
            r_last    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_rpm     <= '0;
            r_epr     <= EPR_RESET;
            r_avg     <= AVG_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration writes; duty is not used by any result
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EPR: r_epr <= i_cfg_data;
                    CFG_AVG: r_avg <= i_cfg_data;
                    default: ;
                endcase
            end

            // Apply commutation at accept
            if (w_accept) begin
                unique case (i_mode)
                    MODE_EDGE: begin
                        if (r_running) begin
                            if (i_hall == HALL_NONE) r_drive <= '0;
                            else if (i_hall != HALL_ALL) r_drive <= commutate(i_hall);
                        end else if (r_pending && w_hall_ok) begin
                            r_running <= 1'b1;
                            r_pending <= 1'b0;
                            r_drive   <= commutate(i_hall);
                        end
                        r_last <= i_time_ms;
                    end
                    MODE_START: begin
                        if (!r_running) begin
                            if (w_hall_ok) begin
                                r_running <= 1'b1;
                                r_pending <= 1'b0;
                                r_drive   <= commutate(i_hall);
                            end else begin
                                r_pending <= 1'b1;
                            end
                        end
                    end
                    MODE_STOP: begin
                        r_running <= 1'b0;
                        r_pending <= 1'b0;
                        r_drive   <= '0;
                    end
                    default: ;
                endcase
            end

            // Accumulate the sample, clear on publish
            if (r_state == ST_ACC) begin
                r_sum   <= w_publish ? 24'd0 : w_sum_next;
                r_count <= w_publish ? 8'd0 : w_count_next;
            end

            // Publish saturated average
            if ((r_state == ST_DIV_AVG) && w_last_step) begin
                r_rpm <= (w_quo_next[23:16] != 8'd0) ? RPM_SAT : w_quo_next[15:0];
            end

            // Hand the result to the output register
            if ((r_state == ST_DONE) && w_out_free) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_period  <= i_time_ms - r_last;
            r_updated <= 1'b0;
            r_invalid <= ((i_mode == MODE_EDGE) || (i_mode == MODE_START)) && !w_hall_ok;
        end

        // Special periods skip the sample divide
        if (r_state == ST_MUL) begin
            r_sample <= w_period_zero ? RPM_SAT : 16'd0;
            r_den    <= w_den;
            r_rem    <= '0;
            r_quo    <= {RPM_NUM, 8'd0};
            r_step   <= SAMPLE_LAST;
        end

        // Advance one quotient bit
        if (w_div_run) begin
            r_rem  <= w_rem_next;
            r_quo  <= w_quo_next;
            r_step <= r_step - 5'd1;
        end

        if ((r_state == ST_DIV_SAMPLE) && w_last_step) r_sample <= w_quo_next[15:0];

        // Load the average divide
        if (r_state == ST_ACC) begin
            r_rem  <= '0;
            r_quo  <= w_sum_next;
            r_step <= AVG_LAST;
        end

        if ((r_state == ST_DIV_AVG) && w_last_step) r_updated <= 1'b1;

        // Capture the result snapshot
        if ((r_state == ST_DONE) && w_out_free) begin
            r_o_drive   <= r_drive;
            r_o_gate    <= r_running;
            r_o_rpm     <= r_rpm;
            r_o_updated <= r_updated;
            r_o_invalid <= r_invalid;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_drive_a      = r_o_drive[1:0];
    assign o_drive_b      = r_o_drive[3:2];
    assign o_drive_c      = r_o_drive[5:4];
    assign o_gate_enable  = r_o_gate;
    assign o_rpm          = r_o_rpm;
    assign o_rpm_updated  = r_o_updated;
    assign o_hall_invalid = r_o_invalid;

endmodule
